// ===== design/lotbg_pkg.sv =====
// Shared constants, operation codes and status types for the three-operand lcm block.
`timescale 1ns / 1ps

package lotbg_pkg;

  // Operand width actually used (the low bits of each input port)
  localparam int OPERAND_BITS = 32;
  // Fixed port widths
  localparam int INPUT_BITS   = 32;
  localparam int LCM_BITS     = 63;

  // Derived datapath widths
  localparam int WIDE_BITS    = 2 * OPERAND_BITS;
  localparam int PROD_BITS    = 3 * OPERAND_BITS;
  localparam int EXT_BITS     = (PROD_BITS > LCM_BITS + 1) ? PROD_BITS : LCM_BITS + 1;
  localparam int SHIFT_BITS   = $clog2(WIDE_BITS);
  localparam int CNT_BITS     = $clog2(WIDE_BITS);

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_GCD1_INIT,
    OP_GCD2_INIT,
    OP_GCD_STEP,
    OP_DIV1_INIT,
    OP_DIV2_INIT,
    OP_DIV_STEP,
    OP_MUL1_INIT,
    OP_MUL2_INIT,
    OP_MUL_STEP,
    OP_FINISH
  } op_e;

  // Datapath status seen by the controller
  typedef struct packed {
    logic operand_zero;
    logic gcd_done;
    logic count_last;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== design/lotbg_ctrl.sv =====
// Controller state machine sequencing gcd, divide and multiply for the lcm block.
`timescale 1ns / 1ps

module lotbg_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  lotbg_pkg::dp_status_t status_i,
  output lotbg_pkg::op_e        op_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_GCD1,
    S_DIV1,
    S_MUL1_LD,
    S_MUL1,
    S_PAIR,
    S_GCD2,
    S_DIV2,
    S_MUL2_LD,
    S_MUL2,
    S_FIN
  } state_e;

  state_e state_q, state_d;

  // Take a new item only when idle
  assign in_ready_o = (state_q == S_IDLE);

  // Next state and operation select
  always_comb begin
    state_d = state_q;
    op_o    = lotbg_pkg::OP_IDLE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = lotbg_pkg::OP_LOAD;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.operand_zero) begin
          state_d = S_FIN;
        end else begin
          op_o    = lotbg_pkg::OP_GCD1_INIT;
          state_d = S_GCD1;
        end
      end
      S_GCD1: begin
        if (status_i.gcd_done) begin
          op_o    = lotbg_pkg::OP_DIV1_INIT;
          state_d = S_DIV1;
        end else begin
          op_o = lotbg_pkg::OP_GCD_STEP;
        end
      end
      S_DIV1: begin
        op_o = lotbg_pkg::OP_DIV_STEP;
        if (status_i.count_last) begin
          state_d = S_MUL1_LD;
        end
      end
      S_MUL1_LD: begin
        op_o    = lotbg_pkg::OP_MUL1_INIT;
        state_d = S_MUL1;
      end
      S_MUL1: begin
        op_o = lotbg_pkg::OP_MUL_STEP;
        if (status_i.count_last) begin
          state_d = S_PAIR;
        end
      end
      S_PAIR: begin
        op_o    = lotbg_pkg::OP_GCD2_INIT;
        state_d = S_GCD2;
      end
      S_GCD2: begin
        if (status_i.gcd_done) begin
          op_o    = lotbg_pkg::OP_DIV2_INIT;
          state_d = S_DIV2;
        end else begin
          op_o = lotbg_pkg::OP_GCD_STEP;
        end
      end
      S_DIV2: begin
        op_o = lotbg_pkg::OP_DIV_STEP;
        if (status_i.count_last) begin
          state_d = S_MUL2_LD;
        end
      end
      S_MUL2_LD: begin
        op_o    = lotbg_pkg::OP_MUL2_INIT;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        op_o = lotbg_pkg::OP_MUL_STEP;
        if (status_i.count_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // Hold until the output register is free
        if (!status_i.out_busy) begin
          op_o    = lotbg_pkg::OP_FINISH;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/lotbg_dp.sv =====
// Datapath: binary gcd unit, serial divider, serial multiplier and output register.
`timescale 1ns / 1ps

module lotbg_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lotbg_pkg::op_e                       op_i,
  output lotbg_pkg::dp_status_t                status_o,
  input  logic [lotbg_pkg::INPUT_BITS-1:0]     first_value_i,
  input  logic [lotbg_pkg::INPUT_BITS-1:0]     second_value_i,
  input  logic [lotbg_pkg::INPUT_BITS-1:0]     third_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [lotbg_pkg::LCM_BITS-1:0]       lcm_value_o,
  output logic                                 overflowed_o
);

  localparam int OB   = lotbg_pkg::OPERAND_BITS;
  localparam int WB   = lotbg_pkg::WIDE_BITS;
  localparam int PB   = lotbg_pkg::PROD_BITS;
  localparam int EB   = lotbg_pkg::EXT_BITS;
  localparam int LB   = lotbg_pkg::LCM_BITS;
  localparam int SB   = lotbg_pkg::SHIFT_BITS;
  localparam int CB   = lotbg_pkg::CNT_BITS;

  // Operands and zero flag
  logic [OB-1:0] a_q, b_q, c_q;
  logic          zero_q;
  // Gcd unit
  logic [WB-1:0] x_q, x_d, y_q, y_d;
  logic [SB-1:0] k_q, k_d;
  logic [WB-1:0] gcd_full;
  // Divider
  logic [OB-1:0] div_q, rem_q, rem_d;
  logic [WB-1:0] quo_q, quo_d;
  logic [OB:0]   trial;
  logic          trial_ge;
  // Multiplier
  logic [WB-1:0] md_q, md_d;
  logic [OB-1:0] mr_q, mr_d;
  logic [PB-1:0] acc_q, acc_d;
  logic [WB:0]   mul_sum;
  // Step counter
  logic [CB-1:0] cnt_q, cnt_d;
  // Output register
  logic          out_valid_q, out_valid_d;
  logic [LB-1:0] lcm_q, lcm_d;
  logic          ovf_q, ovf_d;
  logic [EB-1:0] prod_ext;

  // Gcd value once the loop has drained
  assign gcd_full = x_q << k_q;

  // Restoring divide trial subtract
  assign trial    = {rem_q, quo_q[WB-1]};
  assign trial_ge = (trial >= {1'b0, div_q});

  // Shift-add multiply partial sum
  assign mul_sum  = {1'b0, acc_q[PB-1:OB]} + (mr_q[0] ? {1'b0, md_q} : '0);

  assign prod_ext = EB'(acc_q);

  // Next values for the working registers
  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    k_d   = k_q;
    rem_d = rem_q;
    quo_d = quo_q;
    md_d  = md_q;
    mr_d  = mr_q;
    acc_d = acc_q;
    cnt_d = cnt_q;
    case (op_i)
      lotbg_pkg::OP_GCD1_INIT: begin
        x_d = WB'(a_q);
        y_d = WB'(b_q);
        k_d = '0;
      end
      lotbg_pkg::OP_GCD2_INIT: begin
        x_d = acc_q[WB-1:0];
        y_d = WB'(c_q);
        k_d = '0;
      end
      lotbg_pkg::OP_GCD_STEP: begin
        if (!x_q[0] && !y_q[0]) begin
          // Strip a common factor of two
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (x_q > y_q) begin
          // Swap so the smaller comes first, then subtract
          x_d = y_q;
          y_d = x_q - y_q;
        end else begin
          y_d = y_q - x_q;
        end
      end
      lotbg_pkg::OP_DIV1_INIT: begin
        quo_d = WB'(a_q);
        rem_d = '0;
        cnt_d = CB'(WB - 1);
      end
      lotbg_pkg::OP_DIV2_INIT: begin
        quo_d = acc_q[WB-1:0];
        rem_d = '0;
        cnt_d = CB'(WB - 1);
      end
      lotbg_pkg::OP_DIV_STEP: begin
        rem_d = trial_ge ? OB'(trial - {1'b0, div_q}) : trial[OB-1:0];
        quo_d = {quo_q[WB-2:0], trial_ge};
        cnt_d = cnt_q - 1'b1;
      end
      lotbg_pkg::OP_MUL1_INIT: begin
        md_d  = quo_q;
        mr_d  = b_q;
        acc_d = '0;
        cnt_d = CB'(OB - 1);
      end
      lotbg_pkg::OP_MUL2_INIT: begin
        md_d  = quo_q;
        mr_d  = c_q;
        acc_d = '0;
        cnt_d = CB'(OB - 1);
      end
      lotbg_pkg::OP_MUL_STEP: begin
        acc_d = {mul_sum, acc_q[OB-1:1]};
        mr_d  = mr_q >> 1;
        cnt_d = cnt_q - 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Load the output register with zero, the saturated maximum or the final product
  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    lcm_d       = lcm_q;
    ovf_d       = ovf_q;
    if (op_i == lotbg_pkg::OP_FINISH) begin
      out_valid_d = 1'b1;
      if (zero_q) begin
        lcm_d = '0;
        ovf_d = 1'b0;
      end else if (|prod_ext[EB-1:LB]) begin
        lcm_d = '1;
        ovf_d = 1'b1;
      end else begin
        lcm_d = prod_ext[LB-1:0];
        ovf_d = 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (op_i == lotbg_pkg::OP_LOAD) begin
      a_q    <= first_value_i[OB-1:0];
      b_q    <= second_value_i[OB-1:0];
      c_q    <= third_value_i[OB-1:0];
      zero_q <= (first_value_i[OB-1:0] == '0) || (second_value_i[OB-1:0] == '0) ||
                (third_value_i[OB-1:0] == '0);
    end
    if (op_i == lotbg_pkg::OP_DIV1_INIT || op_i == lotbg_pkg::OP_DIV2_INIT) begin
      div_q <= gcd_full[OB-1:0];
    end
    x_q   <= x_d;
    y_q   <= y_d;
    k_q   <= k_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    md_q  <= md_d;
    mr_q  <= mr_d;
    acc_q <= acc_d;
    cnt_q <= cnt_d;
    lcm_q <= lcm_d;
    ovf_q <= ovf_d;
  end

  // Output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.operand_zero = zero_q;
  assign status_o.gcd_done     = (y_q == '0);
  assign status_o.count_last   = (cnt_q == '0);
  assign status_o.out_busy     = out_valid_q & ~out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign lcm_value_o  = lcm_q;
  assign overflowed_o = ovf_q;

endmodule

// ===== design/lcm_of_three_binary_gcd.sv =====
// Top level of the three-operand lcm block: controller plus datapath.
// When any operand is zero the controller skips to the result, which is then zero;
//   otherwise it runs the two binary gcd loops, each followed by a divide and a multiply.
// The divides are 64-step restoring divides and the multiplies 32-step shift-add
//   multiplies; each gcd loop takes one step per cycle; one item is in flight at a time.
// The output register holds a result until taken while the next item is accepted.
// Reset clears the controller and the output valid flag; no other state is kept.
`timescale 1ns / 1ps

module lcm_of_three_binary_gcd (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [lotbg_pkg::INPUT_BITS-1:0] first_value_i,
  input  logic [lotbg_pkg::INPUT_BITS-1:0] second_value_i,
  input  logic [lotbg_pkg::INPUT_BITS-1:0] third_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [lotbg_pkg::LCM_BITS-1:0]   lcm_value_o,
  output logic                             overflowed_o
);

  lotbg_pkg::op_e        op;
  lotbg_pkg::dp_status_t status;

  // Sequence the work
  lotbg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .op_o       (op)
  );

  // Compute
  lotbg_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .status_o       (status),
    .first_value_i  (first_value_i),
    .second_value_i (second_value_i),
    .third_value_i  (third_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .lcm_value_o    (lcm_value_o),
    .overflowed_o   (overflowed_o)
  );

`ifndef SYNTHESIS
  // One item at a time: no new item right after one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item accepted while previous item still in work");

  // Saturated results read as the maximum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflowed_o) |-> (&lcm_value_o))
    else $error("overflow flagged without saturated value");

  // A new result only appears from a busy controller
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result raised while controller was idle");
`endif

endmodule
